// ===== rtl/tep_pkg.sv =====
// ----------------------------------------------------------------------------
// tep_pkg
// Shared types and constants of the tagged entry reply parser: parse phases,
// verdict codes, register indexes, the register set and the result beat.
// ----------------------------------------------------------------------------
package tep_pkg;

	// Fixed reply layout
	localparam logic [3:0] STATUS_LEN    = 4'd2;
	localparam logic [3:0] HEADER_LEN    = 4'd8;
	localparam logic [3:0] ENTRY_HDR_LEN = 4'd12;

	// Byte positions inside an entry header
	localparam logic [3:0] EH_LEN_LO = 4'd4;
	localparam logic [3:0] EH_LEN_HI = 4'd5;
	localparam logic [3:0] EH_SUB_LO = 4'd8;
	localparam logic [3:0] EH_SUB_HI = 4'd9;

	// Required value of the status word
	localparam logic [7:0] STATUS_OK = 8'h00;

	// Register indexes
	localparam logic [1:0] CFG_WANTED_SUBTAG = 2'd0;
	localparam logic [1:0] CFG_MAX_VALUE_LEN = 2'd1;
	localparam logic [1:0] CFG_SKIP_BYTES    = 2'd2;

	// Register reset values
	localparam logic [15:0] WANTED_SUBTAG_RST = 16'd3;
	localparam logic [15:0] MAX_VALUE_LEN_RST = 16'd4096;
	localparam logic [7:0]  SKIP_BYTES_RST    = 8'd4;

	// Verdict codes
	localparam logic [3:0] RC_FOUND        = 4'd0;
	localparam logic [3:0] RC_ABSENT       = 4'd1;
	localparam logic [3:0] RC_NO_STATUS    = 4'd2;
	localparam logic [3:0] RC_BAD_STATUS   = 4'd3;
	localparam logic [3:0] RC_SHORT_HEADER = 4'd4;
	localparam logic [3:0] RC_TRUNC_HDR    = 4'd5;
	localparam logic [3:0] RC_TRUNC_VALUE  = 4'd6;
	localparam logic [3:0] RC_TOO_LARGE    = 4'd7;
	localparam logic [3:0] RC_GARBAGE      = 4'd8;
	localparam logic [3:0] RC_SHORT        = 4'd9;

	// Latched error: none yet
	localparam logic [3:0] ERR_NONE = 4'd0;

	typedef enum logic [2:0] {
		PH_STATUS,
		PH_HEADER,
		PH_EHDR,
		PH_VALUE,
		PH_TRAIL,
		PH_ERROR
	} phase_t;

	typedef struct packed {
		logic [15:0] wanted_subtag;
		logic [15:0] max_value_len;
		logic [7:0]  skip_bytes;
	} cfg_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  value_byte;
		logic [15:0] value_offset;
		logic        done_res;
		logic [3:0]  result_code;
		logic [15:0] value_length;
	} res_t;

endpackage

// ===== rtl/tep_core.sv =====
// ----------------------------------------------------------------------------
// tep_core
// Parse state of the reply. Takes one byte per step, updates the phase and
// field counters, and forms the result beat that the byte causes.
// ----------------------------------------------------------------------------
module tep_core (
	input  logic          clk,
	input  logic          arst_n,
	input  tep_pkg::cfg_t cfg,
	input  logic          step,
	input  logic [7:0]    reply_byte,
	input  logic          last_byte,
	output logic          has_res,
	output tep_pkg::res_t res
);
	import tep_pkg::*;

	phase_t      phase_q, phase_n;
	logic [3:0]  cnt_q, cnt_n;
	logic [31:0] entries_q, entries_n;
	logic [15:0] pos_q, pos_n;
	logic [15:0] len_q, len_n;
	logic [15:0] sub_q, sub_n;
	logic        match_q, match_n;
	logic        found_q, found_n;
	logic [15:0] win_q, win_n;
	logic [3:0]  err_q, err_n;

	logic        finish;
	logic        emit;
	logic        too_big;
	logic [31:0] entries_dec;
	logic [15:0] skip_ext;

	assign skip_ext    = {8'd0, cfg.skip_bytes};
	assign too_big     = len_q > cfg.max_value_len;
	assign entries_dec = entries_q - 32'd1;

	// Next state
	always_comb begin
		phase_n   = phase_q;
		cnt_n     = cnt_q;
		entries_n = entries_q;
		pos_n     = pos_q;
		len_n     = len_q;
		sub_n     = sub_q;
		match_n   = match_q;
		found_n   = found_q;
		win_n     = win_q;
		err_n     = err_q;
		finish    = 1'b0;
		emit      = 1'b0;
		unique case (phase_q)
			PH_STATUS: begin
				if (reply_byte != STATUS_OK) begin
					err_n = RC_BAD_STATUS;
				end
				cnt_n = cnt_q + 4'd1;
				if (cnt_n == STATUS_LEN) begin
					cnt_n   = 4'd0;
					phase_n = (err_n != ERR_NONE) ? PH_ERROR : PH_HEADER;
				end
			end
			PH_HEADER: begin
				// second header word is the entry count
				if (cnt_q[2]) begin
					entries_n[{cnt_q[1:0], 3'b000} +: 8] = reply_byte;
				end
				cnt_n = cnt_q + 4'd1;
				if (cnt_n == HEADER_LEN) begin
					cnt_n   = 4'd0;
					phase_n = (entries_n != 32'd0) ? PH_EHDR : PH_TRAIL;
				end
			end
			PH_EHDR: begin
				if (cnt_q == EH_LEN_LO) begin
					len_n = {8'd0, reply_byte};
				end else if (cnt_q == EH_LEN_HI) begin
					len_n[15:8] = reply_byte;
				end else if (cnt_q == EH_SUB_LO) begin
					sub_n = {8'd0, reply_byte};
				end else if (cnt_q == EH_SUB_HI) begin
					sub_n[15:8] = reply_byte;
				end
				cnt_n = cnt_q + 4'd1;
				if (cnt_n == ENTRY_HDR_LEN) begin
					cnt_n   = 4'd0;
					match_n = (sub_q == cfg.wanted_subtag);
					pos_n   = 16'd0;
					if (len_q == 16'd0) begin
						finish = 1'b1;
					end else begin
						phase_n = PH_VALUE;
					end
				end
			end
			PH_VALUE: begin
				// pass the byte once the skip slice is behind us
				emit  = match_q && !too_big && (pos_q >= skip_ext);
				pos_n = pos_q + 16'd1;
				if (pos_n == len_q) begin
					finish = 1'b1;
				end
			end
			PH_TRAIL: begin
				err_n   = RC_GARBAGE;
				phase_n = PH_ERROR;
			end
			PH_ERROR: begin
			end
			default: begin
			end
		endcase

		// Close the entry: reject an oversized winner, else count it down
		if (finish) begin
			if (match_n && too_big) begin
				err_n   = RC_TOO_LARGE;
				phase_n = PH_ERROR;
			end else begin
				if (match_n) begin
					found_n = 1'b1;
					win_n   = len_q;
				end
				entries_n = entries_dec;
				cnt_n     = 4'd0;
				phase_n   = (entries_dec != 32'd0) ? PH_EHDR : PH_TRAIL;
			end
		end
	end

	// Result beat
	always_comb begin
		res         = '0;
		has_res     = emit || last_byte;
		res.byte_valid = emit;
		if (emit) begin
			res.value_byte   = reply_byte;
			res.value_offset = pos_q - skip_ext;
		end
		res.done_res = last_byte;
		if (last_byte) begin
			unique case (phase_n)
				PH_STATUS: res.result_code = RC_NO_STATUS;
				PH_HEADER: res.result_code = RC_SHORT_HEADER;
				PH_EHDR:   res.result_code = RC_TRUNC_HDR;
				PH_VALUE:  res.result_code = RC_TRUNC_VALUE;
				PH_TRAIL: begin
					if (!found_n) begin
						res.result_code = RC_ABSENT;
					end else if (win_n < skip_ext) begin
						res.result_code = RC_SHORT;
					end else begin
						res.result_code  = RC_FOUND;
						res.value_length = win_n - skip_ext;
					end
				end
				default:   res.result_code = err_n;
			endcase
		end
	end

	// Advance on each accepted byte; the final byte restarts the parse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_STATUS;
			cnt_q     <= '0;
			entries_q <= '0;
			pos_q     <= '0;
			len_q     <= '0;
			sub_q     <= '0;
			match_q   <= 1'b0;
			found_q   <= 1'b0;
			win_q     <= '0;
			err_q     <= ERR_NONE;
		end else if (step) begin
			if (last_byte) begin
				phase_q   <= PH_STATUS;
				cnt_q     <= '0;
				entries_q <= '0;
				pos_q     <= '0;
				len_q     <= '0;
				sub_q     <= '0;
				match_q   <= 1'b0;
				found_q   <= 1'b0;
				win_q     <= '0;
				err_q     <= ERR_NONE;
			end else begin
				phase_q   <= phase_n;
				cnt_q     <= cnt_n;
				entries_q <= entries_n;
				pos_q     <= pos_n;
				len_q     <= len_n;
				sub_q     <= sub_n;
				match_q   <= match_n;
				found_q   <= found_n;
				win_q     <= win_n;
				err_q     <= err_n;
			end
		end
	end

endmodule

// ===== rtl/tagged_entry_reply_parser.sv =====
// ----------------------------------------------------------------------------
// tagged_entry_reply_parser
// Parses a tagged-entry device reply byte by byte, streams the value bytes
// of the wanted subtag past the skip slice and gives a verdict on the last
// byte.
// ----------------------------------------------------------------------------
// The beat of an accepted reply byte goes to the result register, or to the
// skid register while the result register is held. Each byte costs a single
// update of the parse state between the input handshake and the result
// register, so the sustained rate is one byte per cycle while in_ready is
// high. The result side has a two-beat buffer (result register plus skid
// register): in_ready drops only while both hold a beat, i.e. once the
// consumer has held off a pending beat at an edge where the next beat
// arrives. A byte that produces no beat (headers, skipped or unmatched value
// bytes) leaves the result side untouched. Registers are written through
// cfg_wr_en / cfg_index / cfg_data and take effect on the next byte; write
// them only while no reply is in flight.
// ----------------------------------------------------------------------------
module tagged_entry_reply_parser (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  reply_byte,
	input  logic        last_byte,

	output logic        out_valid,
	input  logic        out_ready,
	output logic        byte_valid,
	output logic [7:0]  value_byte,
	output logic [15:0] value_offset,
	output logic        done_res,
	output logic [3:0]  result_code,
	output logic [15:0] value_length
);
	import tep_pkg::*;

	cfg_t cfg_q;
	res_t res;
	res_t out_q;
	res_t skid_q;
	logic has_res;
	logic step;
	logic out_valid_q;
	logic skid_valid_q;
	logic out_free;

	assign in_ready = !skid_valid_q;
	assign step     = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wanted_subtag <= WANTED_SUBTAG_RST;
			cfg_q.max_value_len <= MAX_VALUE_LEN_RST;
			cfg_q.skip_bytes    <= SKIP_BYTES_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_WANTED_SUBTAG: cfg_q.wanted_subtag <= cfg_data;
				CFG_MAX_VALUE_LEN: cfg_q.max_value_len <= cfg_data;
				CFG_SKIP_BYTES:    cfg_q.skip_bytes    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	tep_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.step       (step),
		.reply_byte (reply_byte),
		.last_byte  (last_byte),
		.has_res    (has_res),
		.res        (res)
	);

	// Result register and skid: drain skid first, else load the new beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_free) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (step && has_res) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				out_q <= skid_q;
			end
		end else if (step && has_res) begin
			if (out_free) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign byte_valid   = out_q.byte_valid;
	assign value_byte   = out_q.value_byte;
	assign value_offset = out_q.value_offset;
	assign done_res     = out_q.done_res;
	assign result_code  = out_q.result_code;
	assign value_length = out_q.value_length;

	// Skid holds a beat only behind a full result register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid beat without a result beat ahead of it");

	// Skid fills only when the result register was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid loaded while the result register was free");

	// Every beat carries a value byte, a verdict or both
	a_beat_content: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.byte_valid || out_q.done_res))
		else $error("empty result beat");

	// A length is reported only with a found verdict
	a_len_found: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.value_length != 16'd0) |->
		(out_q.done_res && out_q.result_code == RC_FOUND))
		else $error("value length without a found verdict");

endmodule
